[rtl/ils_pkg.sv]
// indexed list store: shared types and constants
// used by ils_ctrl, ils_cell and indexed_list_store_top; depends on nothing

package ils_pkg;

  localparam int OP_W      = 4;
  localparam int POS_W     = 6;
  localparam int VAL_W     = 32;
  localparam int ST_W      = 2;
  localparam int S_TDATA_W = 40;  // position and value, padded to whole bytes

  typedef enum logic [OP_W-1:0] {
    OP_ADD_FRONT = 4'd0,
    OP_ADD_END   = 4'd1,
    OP_ADD_AT    = 4'd2,
    OP_REM_FRONT = 4'd3,
    OP_REM_END   = 4'd4,
    OP_REM_AT    = 4'd5,
    OP_GET_FRONT = 4'd6,
    OP_GET_END   = 4'd7,
    OP_GET_AT    = 4'd8
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CM_HOLD   = 2'd0,
    CM_INSERT = 2'd1,
    CM_REMOVE = 2'd2
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;    // what the cell row does on this transfer
    status_t    status;
    logic       rd_en;   // result carries the entry at the selected position
  } dec_t;

endpackage

[rtl/ils_ctrl.sv]
// indexed list store: request decoder, selects position, status and new count
// depends on ils_pkg

module ils_ctrl #(
  parameter int CAPACITY = 64,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic [ils_pkg::OP_W-1:0]  operation,
  input  logic [ils_pkg::POS_W-1:0] position,
  input  logic [CW-1:0]             count,
  output ils_pkg::dec_t             dec,
  output logic [AW-1:0]             at,
  output logic [CW-1:0]             count_next
);

  localparam int CMPW = (CW > ils_pkg::POS_W) ? CW : ils_pkg::POS_W;

  logic            full;
  logic            empty;
  logic [CW-1:0]   last;
  logic [CMPW-1:0] posx;
  logic [CMPW-1:0] cntx;
  logic [CMPW-1:0] lastx;
  logic [CMPW-1:0] atw;

  assign full  = (count == CW'(CAPACITY));
  assign empty = (count == '0);
  assign last  = count - CW'(1);
  assign posx  = CMPW'(position);
  assign cntx  = CMPW'(count);
  assign lastx = CMPW'(last);
  assign at    = atw[AW-1:0];

  always_comb begin
    dec.mode   = ils_pkg::CM_HOLD;
    dec.status = ils_pkg::ST_RANGE;
    dec.rd_en  = 1'b0;
    atw        = '0;
    count_next = count;
    unique case (operation)
      ils_pkg::OP_ADD_FRONT, ils_pkg::OP_ADD_END, ils_pkg::OP_ADD_AT: begin
        if (full) begin
          dec.status = ils_pkg::ST_FULL;
        end else begin
          dec.mode   = ils_pkg::CM_INSERT;
          dec.status = ils_pkg::ST_OK;
          count_next = count + CW'(1);
          if (operation == ils_pkg::OP_ADD_END) begin
            atw = cntx;
          end else if (operation == ils_pkg::OP_ADD_AT) begin
            atw = (posx > cntx) ? cntx : posx;
          end
        end
      end
      ils_pkg::OP_REM_FRONT, ils_pkg::OP_REM_END, ils_pkg::OP_REM_AT: begin
        if (!empty) begin
          dec.mode   = ils_pkg::CM_REMOVE;
          dec.status = ils_pkg::ST_OK;
          dec.rd_en  = 1'b1;
          count_next = last;
          if (operation == ils_pkg::OP_REM_END) begin
            atw = lastx;
          end else if (operation == ils_pkg::OP_REM_AT) begin
            // a position at or past the tail removes the tail
            atw = (posx >= lastx) ? lastx : posx;
          end
        end
      end
      ils_pkg::OP_GET_FRONT, ils_pkg::OP_GET_END: begin
        if (!empty) begin
          dec.status = ils_pkg::ST_OK;
          dec.rd_en  = 1'b1;
          if (operation == ils_pkg::OP_GET_END) begin
            atw = lastx;
          end
        end
      end
      ils_pkg::OP_GET_AT: begin
        if (posx < cntx) begin
          dec.status = ils_pkg::ST_OK;
          dec.rd_en  = 1'b1;
          atw        = posx;
        end
      end
      default: begin
        // unused codes change nothing and report out of range
        dec.status = ils_pkg::ST_RANGE;
      end
    endcase
  end

endmodule

[rtl/ils_cell.sv]
// indexed list store: one list slot, shifts with its neighbours or loads a value
// depends on ils_pkg

module ils_cell #(
  parameter int AW  = 6,
  parameter int IDX = 0
) (
  input  logic                     clk,
  input  ils_pkg::cell_mode_t      mode,
  input  logic [AW-1:0]            at,
  input  logic [ils_pkg::VAL_W-1:0] value,
  input  logic [ils_pkg::VAL_W-1:0] from_left,
  input  logic [ils_pkg::VAL_W-1:0] from_right,
  output logic [ils_pkg::VAL_W-1:0] q,
  output logic [ils_pkg::VAL_W-1:0] tap
);

  localparam logic [AW-1:0] ME = AW'(IDX);

  logic [ils_pkg::VAL_W-1:0] q_next;

  always_comb begin
    q_next = q;
    case (mode)
      ils_pkg::CM_INSERT: begin
        if (ME > at) begin
          q_next = from_left;
        end else if (ME == at) begin
          q_next = value;
        end
      end
      ils_pkg::CM_REMOVE: begin
        if (ME >= at) begin
          q_next = from_right;
        end
      end
      default: begin
        q_next = q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

  // read tap, zero unless this slot is the selected one
  assign tap = (ME == at) ? q : '0;

endmodule

[rtl/indexed_list_store_top.sv]
// indexed list store: top level, row of list cells, decoder and result register
// depends on ils_pkg, ils_ctrl and ils_cell
//
// usage
//   requests arrive on the s_axis channel: the operation code on s_axis_tuser,
//   position and value on s_axis_tdata; every request gives exactly one result
//   on the m_axis channel with the value read or removed, the count after the
//   request and a status (ok, empty or out of range, full)
//   the list is a row of CAPACITY cells; an insert shifts every cell above the
//   insert point one place up, a remove shifts every cell from the removal point
//   one place down, all in the same clock, and reads select one cell by position
// latency and throughput
//   a result appears on m_axis in the cycle after its request transfer; one
//   request is taken every cycle while m_axis_tready stays high, set by the cell
//   row updating at the request transfer and the registered result stage
// reset
//   rst empties the list and drops m_axis_tvalid; cell contents are left as
//   they are since only slots below the count are ever read
// stalls
//   while a result waits with m_axis_tready low, s_axis_tready is low; the
//   result register frees in the cycle the result transfer happens, so a new
//   request may be taken in that same cycle

module indexed_list_store_top #(
  parameter int CAPACITY = 64,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int M_TDATA_W = ((ils_pkg::VAL_W + CW + ils_pkg::ST_W + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ils_pkg::S_TDATA_W-1:0] s_axis_tdata,   // position, value, zero pad
  input  logic [ils_pkg::OP_W-1:0]      s_axis_tuser,   // operation
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [M_TDATA_W-1:0]          m_axis_tdata    // read_value, entries, status, zero pad
);

  localparam int AW = $clog2(CAPACITY);
  localparam int VW = ils_pkg::VAL_W;
  localparam int PW = ils_pkg::POS_W;

  logic                accept;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [AW-1:0]       at;
  ils_pkg::dec_t       dec;
  ils_pkg::cell_mode_t cell_mode;
  logic [PW-1:0]       position;
  logic [VW-1:0]       value;
  logic [VW-1:0]       rd_any;
  logic [VW-1:0]       read_value;

  // cell outputs and read taps, one per slot
  logic [VW-1:0] slot [CAPACITY];
  logic [VW-1:0] taps [CAPACITY];

  // request fields
  assign position = s_axis_tdata[PW-1:0];
  assign value    = s_axis_tdata[PW+VW-1:PW];

  // result register is free when empty or being drained this cycle
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  ils_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .operation  (s_axis_tuser),
    .position   (position),
    .count      (count),
    .dec        (dec),
    .at         (at),
    .count_next (count_next)
  );

  // the row only moves on a request transfer
  assign cell_mode = accept ? dec.mode : ils_pkg::CM_HOLD;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VW-1:0] left_in;
    logic [VW-1:0] right_in;

    // slot zero never takes from the left; the top slot keeps itself on remove
    if (i == 0) begin : g_first
      assign left_in = value;
    end else begin : g_mid_l
      assign left_in = slot[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_in = slot[i];
    end else begin : g_mid_r
      assign right_in = slot[i+1];
    end

    ils_cell #(
      .AW  (AW),
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .mode       (cell_mode),
      .at         (at),
      .value      (value),
      .from_left  (left_in),
      .from_right (right_in),
      .q          (slot[i]),
      .tap        (taps[i])
    );
  end

  // one-hot read: only the selected slot drives a nonzero tap
  always_comb begin
    rd_any = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_any = rd_any | taps[i];
    end
  end

  // adds and failed requests return zero
  assign read_value = dec.rd_en ? rd_any : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count         <= count_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= M_TDATA_W'({dec.status, count_next, read_value});
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_entries_match: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_axis_tdata[VW+CW-1:VW] == count)
    else $error("reported entries differ from held count");

  a_full_only_at_cap: assert property (@(posedge clk) disable iff (rst)
    accept && dec.status == ils_pkg::ST_FULL |-> count == CW'(CAPACITY))
    else $error("full status on a list with room");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    accept && dec.mode == ils_pkg::CM_INSERT |=> count == $past(count) + CW'(1))
    else $error("insert did not grow the count by one");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    accept && dec.mode == ils_pkg::CM_REMOVE |=> count == $past(count) - CW'(1))
    else $error("remove did not shrink the count by one");
`endif

endmodule

[tb/sv/testbench.sv]
// testbench for indexed_list_store_top: directed and random list requests checked
// against a list predictor in this file; depends on ils_pkg and the rtl top level

module testbench;

  localparam int CAPACITY  = 64;
  localparam int M_TDATA_W = 48;  // read_value, entries, status, zero pad

  // operation codes outside the decoded set, answered with a range status
  localparam logic [ils_pkg::OP_W-1:0] OP_UNUSED_FIRST = 4'd9;
  localparam logic [ils_pkg::OP_W-1:0] OP_UNUSED_LAST  = 4'd15;
  localparam int                       UNUSED_SPAN     = 6;

  localparam logic [ils_pkg::VAL_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [ils_pkg::VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

  localparam int MAX_REPORTS  = 10;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 480;
  localparam int DRAIN_CYCLES = 4;

  typedef struct {
    logic [ils_pkg::VAL_W-1:0] read_value;
    logic [6:0]                entries;
    ils_pkg::status_t          status;
  } list_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [ils_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;  // position, value, zero pad
  logic [ils_pkg::OP_W-1:0]      s_axis_tuser = '0;  // operation
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]          m_axis_tdata;  // read_value, entries, status, zero pad

  // predictor state: list contents and count as the block should hold them
  logic [ils_pkg::VAL_W-1:0] list_mem [CAPACITY];
  int                        list_count = 0;
  list_result_t              pending_results [$];

  int  error_count   = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_request  = 0;
  int  hold_left     = 0;
  bit  grow_list     = 1'b1;

  indexed_list_store_top #(.CAPACITY(CAPACITY)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // list behaviour of one request: updates the predicted list and gives the result
  function automatic list_result_t apply_request(input logic [ils_pkg::OP_W-1:0] op,
                                                 input logic [ils_pkg::POS_W-1:0] pos,
                                                 input logic [ils_pkg::VAL_W-1:0] val);
    list_result_t r;
    int           at;
    r.read_value = '0;
    r.status     = ils_pkg::ST_OK;
    case (op)
      ils_pkg::OP_ADD_FRONT, ils_pkg::OP_ADD_END, ils_pkg::OP_ADD_AT: begin
        if (list_count >= CAPACITY) begin
          r.status = ils_pkg::ST_FULL;
        end else begin
          if (op == ils_pkg::OP_ADD_FRONT) at = 0;
          else if (op == ils_pkg::OP_ADD_END) at = list_count;
          else at = int'(pos);
          // positions past the end append
          if (at > list_count) at = list_count;
          for (int i = list_count; i > at; i--) list_mem[i] = list_mem[i-1];
          list_mem[at] = val;
          list_count++;
        end
      end
      ils_pkg::OP_REM_FRONT, ils_pkg::OP_REM_END, ils_pkg::OP_REM_AT: begin
        if (list_count == 0) begin
          r.status = ils_pkg::ST_RANGE;
        end else begin
          if (op == ils_pkg::OP_REM_FRONT) at = 0;
          else if (op == ils_pkg::OP_REM_END) at = list_count - 1;
          else at = int'(pos);
          // a remove is never out of range once the list holds something
          if (at >= list_count - 1) at = list_count - 1;
          r.read_value = list_mem[at];
          for (int i = at; i + 1 < list_count; i++) list_mem[i] = list_mem[i+1];
          list_count--;
        end
      end
      ils_pkg::OP_GET_FRONT, ils_pkg::OP_GET_END, ils_pkg::OP_GET_AT: begin
        if (op == ils_pkg::OP_GET_FRONT) at = 0;
        else if (op == ils_pkg::OP_GET_END) at = list_count - 1;
        else at = int'(pos);
        if (list_count == 0 || at >= list_count) r.status = ils_pkg::ST_RANGE;
        else r.read_value = list_mem[at];
      end
      default: r.status = ils_pkg::ST_RANGE;
    endcase
    r.entries = 7'(list_count);
    return r;
  endfunction

  // offers one request, after a random idle gap, and records its result on transfer
  task automatic send_request(input logic [ils_pkg::OP_W-1:0] op,
                              input logic [ils_pkg::POS_W-1:0] pos,
                              input logic [ils_pkg::VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, val, pos};
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_results.push_back(apply_request(op, pos, val));
  endtask

  // sender goes quiet until every outstanding result has been seen
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending_results.size() == 0);
    @(posedge clk);
  endtask

  // random request, biased to grow or shrink so the list swings between empty and full
  task automatic send_random_request();
    logic [ils_pkg::OP_W-1:0]  op;
    logic [ils_pkg::POS_W-1:0] pos;
    logic [ils_pkg::VAL_W-1:0] val;
    int                        roll;
    int                        add_pct;
    if (list_count >= CAPACITY) grow_list = 1'b0;
    else if (list_count == 0) grow_list = 1'b1;
    else if ($urandom_range(199) == 0) grow_list = !grow_list;
    add_pct = grow_list ? 55 : 15;
    roll = $urandom_range(99);
    if (roll < 4) op = 4'(OP_UNUSED_FIRST + $urandom_range(UNUSED_SPAN));
    else if (roll < 30) op = 4'(ils_pkg::OP_GET_FRONT + $urandom_range(2));
    else if (roll < 30 + add_pct) op = 4'(ils_pkg::OP_ADD_FRONT + $urandom_range(2));
    else op = 4'(ils_pkg::OP_REM_FRONT + $urandom_range(2));
    // positions either anywhere or close to the current end of the list
    roll = $urandom_range(99);
    if (roll < 40) pos = 6'($urandom_range(CAPACITY - 1));
    else if (roll < 70 || list_count < 2) pos = 6'($urandom_range(list_count));
    else pos = 6'(list_count - 1 - $urandom_range(1));
    roll = $urandom_range(99);
    case (roll % 10)
      0:       val = (roll < 50) ? VAL_MIN : VAL_MAX;
      1:       val = (roll < 50) ? '0 : '1;
      default: val = $urandom;
    endcase
    send_request(op, pos, val);
  endtask

  task automatic run_random_phase(input int items, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (items) send_random_request();
    wait_for_results();
  endtask

  // empty list corner cases, appends past the end, reads and removes past the end
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_request(ils_pkg::OP_GET_FRONT, '0, '0);
    send_request(ils_pkg::OP_GET_END, '0, '0);
    send_request(ils_pkg::OP_GET_AT, '0, '0);
    send_request(ils_pkg::OP_REM_FRONT, '0, '0);
    send_request(ils_pkg::OP_REM_END, '0, '0);
    send_request(ils_pkg::OP_REM_AT, '1, '0);
    send_request(OP_UNUSED_FIRST, '0, '0);
    send_request(OP_UNUSED_LAST, '1, '1);
    send_request(ils_pkg::OP_ADD_END, '0, VAL_MIN);
    send_request(ils_pkg::OP_ADD_FRONT, '0, VAL_MAX);
    send_request(ils_pkg::OP_ADD_AT, '1, '1);
    send_request(ils_pkg::OP_ADD_AT, 6'd1, '0);
    send_request(ils_pkg::OP_ADD_AT, '0, 32'h5555_5555);
    send_request(ils_pkg::OP_GET_AT, 6'd4, '0);
    send_request(ils_pkg::OP_GET_AT, 6'd5, '0);
    send_request(ils_pkg::OP_GET_AT, '1, '0);
    send_request(ils_pkg::OP_GET_FRONT, '0, '0);
    send_request(ils_pkg::OP_GET_END, '0, '0);
    send_request(ils_pkg::OP_REM_AT, 6'd3, '0);
    send_request(ils_pkg::OP_REM_AT, '1, '0);
    send_request(ils_pkg::OP_REM_AT, 6'd2, '0);
    send_request(OP_UNUSED_FIRST, 6'd21, 32'hAAAA_AAAA);
    send_request(ils_pkg::OP_REM_END, '0, '0);
    send_request(ils_pkg::OP_REM_FRONT, '0, '0);
    wait_for_results();
  endtask

  task automatic test_no_idle();
    run_random_phase(PHASE_ITEMS, 0, 0);
  endtask

  task automatic test_sender_idle();
    run_random_phase(PHASE_ITEMS, 85, 0);
  endtask

  task automatic test_receiver_stall();
    run_random_phase(PHASE_ITEMS, 0, 85);
  endtask

  task automatic test_both_idle();
    run_random_phase(PHASE_ITEMS, 13, 13);
  endtask

  // long hold-off on the result side while requests keep coming, so input stalls
  task automatic test_output_hold();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = HOLD_CYCLES;
    repeat (40) send_random_request();
    wait_for_results();
  endtask

  // result side: random stalls plus one counted hold-off when asked for
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result check: every transfer against the oldest outstanding expectation
  always @(posedge clk) begin
    list_result_t              want;
    logic [ils_pkg::VAL_W-1:0] got_value;
    logic [6:0]                got_entries;
    logic [ils_pkg::ST_W-1:0]  got_status;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_value   = m_axis_tdata[31:0];
      got_entries = m_axis_tdata[38:32];
      got_status  = m_axis_tdata[40:39];
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected result: value %h entries %0d status %0d",
                   got_value, got_entries, got_status);
      end else begin
        want = pending_results.pop_front();
        if (got_value !== want.read_value || got_entries !== want.entries ||
            got_status !== want.status) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("mismatch: expected value %h entries %0d status %0d, got %h %0d %0d",
                     want.read_value, want.entries, want.status,
                     got_value, got_entries, got_status);
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_output_hold();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // run limit, well beyond the slowest legal run
  initial begin
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
